// ===== rtl/usb_srh_pkg.sv =====
package usb_srh_pkg;

	localparam int EP_COUNT = 16;
	localparam int EP_W = (EP_COUNT > 1) ? $clog2(EP_COUNT) : 1;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	// Reply actions
	localparam logic [1:0] ACT_DATA  = 2'd0;
	localparam logic [1:0] ACT_ZLP   = 2'd1;
	localparam logic [1:0] ACT_STALL = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	// Data sources
	localparam logic [3:0] SRC_DEVICE     = 4'd0;
	localparam logic [3:0] SRC_CONFIG     = 4'd1;
	localparam logic [3:0] SRC_STRING     = 4'd2;
	localparam logic [3:0] SRC_QUALIFIER  = 4'd3;
	localparam logic [3:0] SRC_OTHER      = 4'd4;
	localparam logic [3:0] SRC_CFG_VALUE  = 4'd5;
	localparam logic [3:0] SRC_STATUS     = 4'd6;
	localparam logic [3:0] SRC_LUN        = 4'd7;
	localparam logic [3:0] SRC_ALT        = 4'd8;

	// Recipients and request types
	localparam logic [4:0] RCP_DEVICE    = 5'd0;
	localparam logic [4:0] RCP_INTERFACE = 5'd1;
	localparam logic [4:0] RCP_ENDPOINT  = 5'd2;
	localparam logic [1:0] TYPE_STANDARD = 2'd0;
	localparam logic [1:0] TYPE_CLASS    = 2'd1;

	// Request codes
	localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;
	localparam logic [7:0] REQ_GET_MAX_LUN    = 8'hFE;
	localparam logic [7:0] REQ_MSC_RESET      = 8'hFF;

	// Descriptor types
	localparam logic [7:0] DESC_DEVICE    = 8'd1;
	localparam logic [7:0] DESC_CONFIG    = 8'd2;
	localparam logic [7:0] DESC_STRING    = 8'd3;
	localparam logic [7:0] DESC_QUALIFIER = 8'd6;
	localparam logic [7:0] DESC_OTHER     = 8'd7;
	localparam logic [7:0] STRING_LAST    = 8'd5;

	localparam logic [15:0] FEAT_HALT      = 16'h0000;
	localparam logic [15:0] FEAT_TEST_MODE = 16'h0002;

	// Device states
	localparam logic [1:0] DEV_DEFAULT    = 2'd0;
	localparam logic [1:0] DEV_ADDRESSED  = 2'd1;
	localparam logic [1:0] DEV_CONFIGURED = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_DEVICE_LEN    = 3'd0;
	localparam logic [2:0] CFG_CONFIG_LEN    = 3'd1;
	localparam logic [2:0] CFG_QUALIFIER_LEN = 3'd2;
	localparam logic [2:0] CFG_OTHER_LEN     = 3'd3;
	localparam logic [2:0] CFG_STRING_LENS   = 3'd4;
	localparam logic [2:0] CFG_HIGH_SPEED    = 3'd5;

	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_index;
		logic [15:0] request_length;
	} req_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  data_source;
		logic [2:0]  string_index;
		logic [15:0] tx_length;
		logic [15:0] reply_word;
		logic        address_valid;
		logic [6:0]  new_address;
		logic        test_mode_valid;
		logic [7:0]  test_selector;
		logic [1:0]  device_state;
	} res_t;

	typedef enum logic [3:0] {
		OP_FIXED,
		OP_SET_ADDR,
		OP_SET_CFG,
		OP_GET_CFG,
		OP_DEV_STATUS,
		OP_SET_ALT,
		OP_GET_ALT,
		OP_EP_SET_HALT,
		OP_EP_CLR_HALT,
		OP_EP_STATUS
	} op_t;

	typedef struct packed {
		op_t             op;
		res_t            res;
		logic [7:0]      arg;
		logic [EP_W-1:0] ep_idx;
		logic            ep_in;
		logic            ep_has;
	} cmd_t;

endpackage

// ===== rtl/usb_setup_request_handler.sv =====
// Control-endpoint setup request handler. Each decoded setup packet pushed in
// yields exactly one reply on the result side, in order: the action (data,
// zero-length status, stall or nothing), the data source and byte count for
// data replies, any immediate reply word, address and test-mode commands, and
// the device state after the request. One request is taken per clock while
// the input is not full. A request passes the decode stage, a two-entry command
// queue and the execute stage, which holds device state and endpoint halt bits
// and finishes one command per cycle into its result register while that
// register is free or being popped. A reply that is not popped holds the
// execute stage, and the input reports full once the command queue behind it
// has filled. Descriptor lengths and the speed flag are written through the
// configuration port, always ready; the user must write them only while no
// request is in flight, which the block itself does not enforce.
module usb_setup_request_handler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  usb_srh_pkg::req_t  request,
	output logic               empty,
	input  logic               pop,
	output usb_srh_pkg::res_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);
	import usb_srh_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmdq_empty;
	logic cmd_take;

	assign cfg_ready = 1'b1;

	usb_srh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_in)
	);

	usb_srh_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_take),
		.rdata  (cmd_head),
		.empty  (cmdq_empty)
	);

	usb_srh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmdq_empty),
		.cmd       (cmd_head),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== rtl/usb_srh_front.sv =====
module usb_srh_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  usb_srh_pkg::req_t       request,
	input  logic                    cfg_valid,
	input  logic [2:0]              cfg_index,
	input  logic [47:0]             cfg_data,
	output usb_srh_pkg::cmd_t       cmd
);
	import usb_srh_pkg::*;

	logic [7:0]       device_len_q;
	logic [15:0]      config_len_q;
	logic [7:0]       qualifier_len_q;
	logic [15:0]      other_len_q;
	logic [5:0][7:0]  string_lens_q;
	logic             high_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_len_q    <= 8'd18;
			config_len_q    <= 16'd32;
			qualifier_len_q <= 8'd10;
			other_len_q     <= 16'd32;
			string_lens_q   <= '0;
			high_speed_q    <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEVICE_LEN:    device_len_q    <= cfg_data[7:0];
				CFG_CONFIG_LEN:    config_len_q    <= cfg_data[15:0];
				CFG_QUALIFIER_LEN: qualifier_len_q <= cfg_data[7:0];
				CFG_OTHER_LEN:     other_len_q     <= cfg_data[15:0];
				CFG_STRING_LENS:   string_lens_q   <= cfg_data;
				CFG_HIGH_SPEED:    high_speed_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	function automatic logic [15:0] min_len(input logic [15:0] req, input logic [15:0] len);
		return (req <= len) ? req : len;
	endfunction

	logic [4:0]  recip;
	logic [1:0]  rtype;
	logic [7:0]  dtype;
	logic [7:0]  dindex;
	logic [6:0]  ep_num;
	logic        ep_exists;

	assign recip     = request.request_type[4:0];
	assign rtype     = request.request_type[6:5];
	assign dtype     = request.request_value[15:8];
	assign dindex    = request.request_value[7:0];
	assign ep_num    = request.request_index[6:0];
	assign ep_exists = {1'b0, ep_num} < 8'(EP_COUNT);

	always_comb begin
		cmd = '0;
		cmd.op         = OP_FIXED;
		cmd.res.action = ACT_STALL;
		cmd.arg        = request.request_value[7:0];
		cmd.ep_idx     = ep_num[EP_W-1:0];
		cmd.ep_in      = request.request_index[7];
		cmd.ep_has     = (ep_num != 7'd0) && ep_exists;

		if (recip == RCP_DEVICE) begin
			if (rtype == TYPE_STANDARD) begin
				priority case (request.request_code)
					REQ_GET_DESCRIPTOR: begin
						if (dtype == DESC_DEVICE) begin
							cmd.res.action      = ACT_DATA;
							cmd.res.data_source = SRC_DEVICE;
							cmd.res.tx_length   = min_len(request.request_length,
								{8'h00, device_len_q});
						end else if (dtype == DESC_CONFIG) begin
							cmd.res.action      = ACT_DATA;
							cmd.res.data_source = SRC_CONFIG;
							cmd.res.tx_length   = min_len(request.request_length, config_len_q);
						end else if (dtype == DESC_STRING) begin
							if (dindex <= STRING_LAST) begin
								cmd.res.action       = ACT_DATA;
								cmd.res.data_source  = SRC_STRING;
								cmd.res.string_index = dindex[2:0];
								cmd.res.tx_length    = min_len(request.request_length,
									{8'h00, string_lens_q[dindex[2:0]]});
							end
						end else if (dtype == DESC_QUALIFIER) begin
							if (high_speed_q) begin
								cmd.res.action      = ACT_DATA;
								cmd.res.data_source = SRC_QUALIFIER;
								cmd.res.tx_length   = min_len(request.request_length,
									{8'h00, qualifier_len_q});
							end
						end else if (dtype == DESC_OTHER) begin
							if (high_speed_q) begin
								cmd.res.action      = ACT_DATA;
								cmd.res.data_source = SRC_OTHER;
								cmd.res.tx_length   = min_len(request.request_length, other_len_q);
							end
						end
					end
					REQ_SET_ADDRESS: begin
						cmd.op                = OP_SET_ADDR;
						cmd.res.action        = ACT_ZLP;
						cmd.res.address_valid = 1'b1;
						cmd.res.new_address   = request.request_value[6:0];
					end
					REQ_SET_CONFIG: begin
						cmd.op         = OP_SET_CFG;
						cmd.res.action = ACT_ZLP;
					end
					REQ_GET_CONFIG: begin
						cmd.op              = OP_GET_CFG;
						cmd.res.action      = ACT_DATA;
						cmd.res.data_source = SRC_CFG_VALUE;
						cmd.res.tx_length   = 16'd1;
					end
					REQ_GET_STATUS: begin
						cmd.op              = OP_DEV_STATUS;
						cmd.res.action      = ACT_DATA;
						cmd.res.data_source = SRC_STATUS;
						cmd.res.tx_length   = 16'd2;
					end
					REQ_CLEAR_FEATURE: cmd.res.action = ACT_ZLP;
					REQ_SET_FEATURE: begin
						cmd.res.action = ACT_ZLP;
						if (request.request_value == FEAT_TEST_MODE) begin
							cmd.res.test_mode_valid = 1'b1;
							cmd.res.test_selector   = request.request_index[15:8];
						end
					end
					default: begin
					end
				endcase
			end
		end else if (recip == RCP_INTERFACE) begin
			if (rtype == TYPE_CLASS) begin
				if (request.request_code == REQ_GET_MAX_LUN) begin
					cmd.res.action      = ACT_DATA;
					cmd.res.data_source = SRC_LUN;
					cmd.res.tx_length   = 16'd1;
				end else if (request.request_code == REQ_MSC_RESET) begin
					cmd.res.action = ACT_ZLP;
				end
			end else if (rtype == TYPE_STANDARD) begin
				if (request.request_code == REQ_GET_INTERFACE) begin
					cmd.op              = OP_GET_ALT;
					cmd.res.action      = ACT_DATA;
					cmd.res.data_source = SRC_ALT;
					cmd.res.tx_length   = 16'd1;
				end else if (request.request_code == REQ_SET_INTERFACE) begin
					cmd.op         = OP_SET_ALT;
					cmd.res.action = ACT_ZLP;
				end
			end
		end else if (recip == RCP_ENDPOINT) begin
			priority if (request.request_code == REQ_SET_FEATURE) begin
				// Halting endpoint zero is refused.
				if ((request.request_value == FEAT_HALT) && (ep_num != 7'd0)) begin
					cmd.op         = OP_EP_SET_HALT;
					cmd.res.action = ACT_ZLP;
				end
			end else if (request.request_code == REQ_CLEAR_FEATURE) begin
				if (request.request_value == FEAT_HALT) begin
					cmd.op         = OP_EP_CLR_HALT;
					cmd.res.action = ACT_ZLP;
				end
			end else if (request.request_code == REQ_GET_STATUS) begin
				cmd.op              = OP_EP_STATUS;
				cmd.res.action      = ACT_DATA;
				cmd.res.data_source = SRC_STATUS;
				cmd.res.tx_length   = 16'd2;
			end else begin
				cmd.res.action = ACT_NONE;
			end
		end
	end

endmodule

// ===== rtl/usb_srh_cmdq.sv =====
module usb_srh_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  usb_srh_pkg::cmd_t  wdata,
	output logic               full,
	input  logic               pop,
	output usb_srh_pkg::cmd_t  rdata,
	output logic               empty
);
	import usb_srh_pkg::*;

	cmd_t                mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_AW:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// The depth is a power of two, so the pointers simply wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/usb_srh_back.sv =====
module usb_srh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  usb_srh_pkg::cmd_t  cmd,
	output logic               cmd_take,
	output logic               empty,
	input  logic               pop,
	output usb_srh_pkg::res_t  result
);
	import usb_srh_pkg::*;

	logic [1:0]           dev_state_q;
	logic [7:0]           config_value_q;
	logic [7:0]           alt_setting_q;
	logic [15:0]          last_status_q;
	logic [EP_COUNT-1:0]  in_halt_q;
	logic [EP_COUNT-1:0]  out_halt_q;
	logic                 res_valid_q;
	res_t                 res_q;

	res_t        res_d;
	logic [1:0]  dev_state_d;
	logic        halt_bit;
	logic [15:0] ep_status;

	// A new command moves in whenever the result register is free or being drained.
	assign cmd_take = cmd_valid && (!res_valid_q || pop);
	assign empty    = !res_valid_q;
	assign result   = res_q;

	always_comb begin
		halt_bit    = cmd.ep_in ? in_halt_q[cmd.ep_idx] : out_halt_q[cmd.ep_idx];
		ep_status   = {15'd0, cmd.ep_has && halt_bit};
		res_d       = cmd.res;
		dev_state_d = dev_state_q;
		unique case (cmd.op)
			OP_SET_ADDR:   dev_state_d = DEV_ADDRESSED;
			OP_SET_CFG:    dev_state_d = DEV_CONFIGURED;
			OP_GET_CFG:    res_d.reply_word = {8'h00, config_value_q};
			OP_DEV_STATUS: res_d.reply_word = last_status_q;
			OP_GET_ALT:    res_d.reply_word = {8'h00, alt_setting_q};
			OP_EP_STATUS:  res_d.reply_word = ep_status;
			default: begin
			end
		endcase
		res_d.device_state = dev_state_d;
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q    <= 1'b0;
			dev_state_q    <= DEV_DEFAULT;
			config_value_q <= '0;
			alt_setting_q  <= '0;
			last_status_q  <= '0;
			in_halt_q      <= '0;
			out_halt_q     <= '0;
		end else begin
			if (cmd_take) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			if (cmd_take) begin
				dev_state_q <= dev_state_d;
				unique case (cmd.op)
					OP_SET_CFG:   config_value_q <= cmd.arg;
					OP_SET_ALT:   alt_setting_q  <= cmd.arg;
					OP_EP_STATUS: last_status_q  <= ep_status;
					OP_EP_SET_HALT: begin
						if (cmd.ep_has) begin
							if (cmd.ep_in) begin
								in_halt_q[cmd.ep_idx] <= 1'b1;
							end else begin
								out_halt_q[cmd.ep_idx] <= 1'b1;
							end
						end
					end
					OP_EP_CLR_HALT: begin
						if (cmd.ep_has) begin
							if (cmd.ep_in) begin
								in_halt_q[cmd.ep_idx] <= 1'b0;
							end else begin
								out_halt_q[cmd.ep_idx] <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/usb_srh_checker.sv =====
module usb_srh_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic               empty,
	input  logic               pop,
	input  usb_srh_pkg::res_t  result
);
	import usb_srh_pkg::*;

	// A waiting reply stays put until it is transferred.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("reply changed or vanished while stalled");

	// An accepted request is always followed by a waiting reply.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> ##2 !empty)
		else $error("no reply two cycles after a request transfer");

	// The queue only fills up behind a reply that is waiting.
	a_full_backs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input full with no reply waiting");

	// A new address always leaves the device addressed.
	a_address: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.address_valid) |->
			(result.device_state == DEV_ADDRESSED && result.action == ACT_ZLP))
		else $error("address reply inconsistent");

endmodule

bind usb_setup_request_handler usb_srh_checker u_usb_srh_checker (.*);
